@@ src/hr2ps_pkg.sv @@
// ----------------------------------------------------------------------------
// HID report to PS/2 scancode package
// Scancode tables and constants shared by the converter and its interfaces.
// ----------------------------------------------------------------------------
package hr2ps_pkg;

  localparam int unsigned ROM_ENTRIES = 112;
  localparam int unsigned MOD_BITS    = 8;
  localparam int unsigned MAX_SLOTS   = 6;

  typedef logic [7:0] byte_t;

  localparam byte_t BREAK_BIT = 8'h80;

  // Set-1 make codes for the modifier bits, bit 0 first.
  localparam byte_t MOD_MAKE [0:MOD_BITS-1] = '{
    8'h1D, 8'h2A, 8'h38, 8'h5B, 8'h1D, 8'h36, 8'h38, 8'h5C
  };

  // Usage to set-1 make code; zero means the usage has no code.
  localparam byte_t USAGE_ROM [0:ROM_ENTRIES-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
    8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
    8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
    8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
    8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
    8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h37, 8'h46,
    8'h45, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
    8'h4B, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E,
    8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
    8'h48, 8'h49, 8'h52, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic byte_t usage_code(input byte_t usage);
    byte_t code;
    code = 8'h00;
    if ({1'b0, usage} < 9'(ROM_ENTRIES)) begin
      code = USAGE_ROM[usage[6:0]];
    end
    return code;
  endfunction

endpackage

@@ src/hr2ps_in_if.sv @@
// ----------------------------------------------------------------------------
// HID report channel
// Valid/ready channel carrying one boot-keyboard report per transfer.
// ----------------------------------------------------------------------------
interface hr2ps_in_if;
  logic              valid;
  logic              ready;
  logic              report_complete;
  hr2ps_pkg::byte_t  modifier_bits;
  hr2ps_pkg::byte_t  key_slot_0;
  hr2ps_pkg::byte_t  key_slot_1;
  hr2ps_pkg::byte_t  key_slot_2;
  hr2ps_pkg::byte_t  key_slot_3;
  hr2ps_pkg::byte_t  key_slot_4;
  hr2ps_pkg::byte_t  key_slot_5;

  modport source (
    output valid, report_complete, modifier_bits,
    output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );

  modport sink (
    input  valid, report_complete, modifier_bits,
    input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

@@ src/hr2ps_out_if.sv @@
// ----------------------------------------------------------------------------
// PS/2 scancode channel
// Valid/ready channel carrying one set-1 scancode per transfer.
// ----------------------------------------------------------------------------
interface hr2ps_out_if;
  logic              valid;
  logic              ready;
  hr2ps_pkg::byte_t  scancode;
  logic              last_of_run;

  modport source (
    output valid, scancode, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, scancode, last_of_run,
    output ready
  );
endinterface

@@ src/hid_report_to_ps2_scancodes_unit.sv @@
// ----------------------------------------------------------------------------
// HID report to PS/2 scancode converter
// Compares each complete boot-keyboard report with the previous one and
// emits set-1 make and break codes for the modifiers and keys that changed.
// ----------------------------------------------------------------------------
// A report transfer first registers its pending run, and its first scancode
// is presented once it is loaded from the run into the output register.
// Throughput: one scancode per cycle while the sink is ready; the next
// report is taken in the cycle its predecessor's last code moves to the
// output register, and a report causing nothing frees the emitter at once.
// Reset clears the stored modifiers and keys, the pending run and the output valid flag.
module hid_report_to_ps2_scancodes_unit #(
  parameter int unsigned KEY_SLOTS  = 6,
  parameter int unsigned TABLE_SIZE = 112
) (
  input  logic            clk,
  input  logic            rst,
  hr2ps_in_if.sink        report,
  hr2ps_out_if.source     scan
);

  localparam int unsigned CANDS     = hr2ps_pkg::MOD_BITS + 2 * KEY_SLOTS;
  localparam int unsigned MAKE_BASE = hr2ps_pkg::MOD_BITS;
  localparam int unsigned BRK_BASE  = hr2ps_pkg::MOD_BITS + KEY_SLOTS;

  // Stored state of the last complete report.
  hr2ps_pkg::byte_t prev_modifiers;
  hr2ps_pkg::byte_t prev_keys [KEY_SLOTS];

  // Pending run: one code per candidate position and a mask of those to send.
  hr2ps_pkg::byte_t run_code [CANDS];
  logic [CANDS-1:0] run_mask;
  logic [CANDS-1:0] run_mask_next;

  // Output register.
  logic             out_valid;
  hr2ps_pkg::byte_t out_code;
  logic             out_last;

  hr2ps_pkg::byte_t all_keys [hr2ps_pkg::MAX_SLOTS];
  hr2ps_pkg::byte_t new_keys [KEY_SLOTS];
  hr2ps_pkg::byte_t cand_code [CANDS];
  logic [CANDS-1:0] cand_mask;
  logic [CANDS-1:0] sel;
  logic [CANDS-1:0] remaining;
  logic [CANDS-1:0] mask_after;
  hr2ps_pkg::byte_t sel_code;
  logic             out_load;
  logic             accept;

  function automatic hr2ps_pkg::byte_t mapped_code(input hr2ps_pkg::byte_t usage);
    hr2ps_pkg::byte_t code;
    code = 8'h00;
    if ({1'b0, usage} < 9'(TABLE_SIZE)) begin
      code = hr2ps_pkg::usage_code(usage);
    end
    return code;
  endfunction

  always_comb begin
    all_keys[0] = report.key_slot_0;
    all_keys[1] = report.key_slot_1;
    all_keys[2] = report.key_slot_2;
    all_keys[3] = report.key_slot_3;
    all_keys[4] = report.key_slot_4;
    all_keys[5] = report.key_slot_5;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      new_keys[i] = all_keys[i];
    end
  end

  // Candidate codes for the incoming report against the stored state.
  always_comb begin
    logic             found;
    hr2ps_pkg::byte_t code;
    for (int i = 0; i < hr2ps_pkg::MOD_BITS; i++) begin
      cand_code[i] = report.modifier_bits[i] ? hr2ps_pkg::MOD_MAKE[i]
                                             : (hr2ps_pkg::MOD_MAKE[i] | hr2ps_pkg::BREAK_BIT);
      cand_mask[i] = report.modifier_bits[i] ^ prev_modifiers[i];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        found = found | (prev_keys[j] == new_keys[i]);
      end
      code = mapped_code(new_keys[i]);
      cand_code[MAKE_BASE+i] = code;
      cand_mask[MAKE_BASE+i] = (new_keys[i] != 8'h00) && !found && (code != 8'h00);

      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        found = found | (new_keys[j] == prev_keys[i]);
      end
      code = mapped_code(prev_keys[i]);
      cand_code[BRK_BASE+i] = code | hr2ps_pkg::BREAK_BIT;
      cand_mask[BRK_BASE+i] = (prev_keys[i] != 8'h00) && !found && (code != 8'h00);
    end
  end

  // Lowest pending position goes out first.
  always_comb begin
    sel       = run_mask & (~run_mask + CANDS'(1));
    remaining = run_mask & ~sel;
    sel_code  = 8'h00;
    for (int i = 0; i < CANDS; i++) begin
      sel_code = sel_code | (sel[i] ? run_code[i] : 8'h00);
    end
    out_load   = (run_mask != '0) && (!out_valid || scan.ready);
    mask_after = out_load ? remaining : run_mask;
  end

  assign report.ready = (mask_after == '0);
  assign accept       = report.valid && report.ready;

  always_comb begin
    run_mask_next = mask_after;
    if (accept) begin
      run_mask_next = report.report_complete ? cand_mask : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mask       <= '0;
      prev_modifiers <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
    end else begin
      run_mask <= run_mask_next;
      if (accept && report.report_complete) begin
        prev_modifiers <= report.modifier_bits;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          prev_keys[i] <= new_keys[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && report.report_complete) begin
      for (int i = 0; i < CANDS; i++) begin
        run_code[i] <= cand_code[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (scan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code <= sel_code;
      out_last <= (remaining == '0);
    end
  end

  assign scan.valid       = out_valid;
  assign scan.scancode    = out_code;
  assign scan.last_of_run = out_last;

  // A report is only taken when the pending run is empty or ends this cycle.
  a_ready_run_empty: assert property (@(posedge clk) disable iff (rst)
    report.ready |-> (run_mask == '0) || (out_load && $onehot(run_mask)))
    else $error("report taken while scancodes are still pending");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("loaded scancode not presented");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (out_load && $onehot(run_mask)) |=> out_last)
    else $error("final scancode of a run not marked");

  a_incomplete_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && !report.report_complete) |=>
      (prev_modifiers == $past(prev_modifiers)) && (run_mask == '0))
    else $error("incomplete report changed state or queued scancodes");

endmodule
